// ===== src/assert_macros.svh =====
// assertion macros used by the checker file
// depends on nothing
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent a fixed number of cycles later
`define ASSERT_DELAY(lbl, clk, rst, ante, n, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##(n) (cons)) \
    else $error("assertion failed");

`endif

// ===== src/btpc_pkg.sv =====
// shared types and constants of the barometric compensation block
// depends on nothing
package btpc_pkg;

  localparam int TEMP_FRAC_BITS  = 16;
  localparam int PRESS_FRAC_BITS = 8;
  localparam int ACC_FRAC        = 85;
  localparam int TQ_SHIFT        = 32;
  localparam int TOUT_SHIFT      = 48 - TEMP_FRAC_BITS;
  localparam int P_SHIFT         = ACC_FRAC - PRESS_FRAC_BITS;
  localparam int LATENCY         = 10;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 64;

  localparam logic [1:0] REG_TEMP_TRIM    = 2'd0;
  localparam logic [1:0] REG_PRESS_TRIM_A = 2'd1;
  localparam logic [1:0] REG_PRESS_TRIM_B = 2'd2;
  localparam logic [1:0] REG_PRESS_TRIM_C = 2'd3;

  typedef struct packed {
    logic [23:0] raw_pressure;
    logic [23:0] raw_temperature;
  } req_t;

  typedef struct packed {
    logic signed [23:0] temperature_q16;
    logic [24:0]        pressure_q8;
    logic               saturated;
  } res_t;

  typedef struct packed {
    logic [39:0] temp_trim;
    logic [47:0] press_trim_a;
    logic [47:0] press_trim_b;
    logic [31:0] press_trim_c;
  } trim_t;

endpackage

// ===== src/baro_temp_pressure_compensation.sv =====
// top level: trim register file on the APB port and the compensation pipeline
// depends on btpc_pkg and btpc_pipe
// A request is taken on every cycle that start is high; busy never rises. Each
// request gives one result, marked by done for a single cycle, in request
// order. Results pass through the multiplier pipeline: the temperature
// polynomial takes four stages, the pressure products three, and the wide
// summation, rounding and output register three more. Trim registers sit at
// byte addresses 0, 8, 16 and 24; the user must write them only while no
// request is in flight, and the block itself does not enforce this.
module baro_temp_pressure_compensation (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [btpc_pkg::ADDR_W-1:0]   paddr,
  input  logic [btpc_pkg::DATA_W-1:0]   pwdata,
  output logic [btpc_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          start,
  output logic                          busy,
  input  btpc_pkg::req_t                req,
  output logic                          done,
  output btpc_pkg::res_t                result
);

  btpc_pkg::trim_t trim;
  logic            wr_en;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      trim <= '0;
    end else if (wr_en) begin
      case (paddr[4:3])
        btpc_pkg::REG_TEMP_TRIM:    trim.temp_trim    <= pwdata[39:0];
        btpc_pkg::REG_PRESS_TRIM_A: trim.press_trim_a <= pwdata[47:0];
        btpc_pkg::REG_PRESS_TRIM_B: trim.press_trim_b <= pwdata[47:0];
        btpc_pkg::REG_PRESS_TRIM_C: trim.press_trim_c <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:3])
      btpc_pkg::REG_TEMP_TRIM:    prdata = {24'h000000, trim.temp_trim};
      btpc_pkg::REG_PRESS_TRIM_A: prdata = {16'h0000, trim.press_trim_a};
      btpc_pkg::REG_PRESS_TRIM_B: prdata = {16'h0000, trim.press_trim_b};
      btpc_pkg::REG_PRESS_TRIM_C: prdata = {32'h00000000, trim.press_trim_c};
      default:                    prdata = '0;
    endcase
  end

  btpc_pipe u_pipe (
    .clk     (clk),
    .rst     (rst),
    .in_v    (start & ~busy),
    .in_req  (req),
    .trim    (trim),
    .out_v   (done),
    .out_res (result)
  );

endmodule

// ===== src/btpc_pipe.sv =====
// compensation datapath: temperature polynomial then pressure polynomial
// depends on btpc_pkg
module btpc_pipe (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_v,
  input  btpc_pkg::req_t    in_req,
  input  btpc_pkg::trim_t   trim,
  output logic              out_v,
  output btpc_pkg::res_t    out_res
);

  localparam int XW = 62;
  localparam int AW = 112;
  localparam logic signed [XW-1:0] T_MIN = -62'sd8388608;
  localparam logic signed [XW-1:0] T_MAX = 62'sd8388607;

  // trim fields
  logic [15:0]        t1;
  logic signed [16:0] t2s;
  logic signed [7:0]  t3;
  logic signed [16:0] p1m, p2m, p5s, p6s;
  logic signed [7:0]  p3, p4, p7, p8, p10, p11;
  logic signed [15:0] p9;

  assign t1  = trim.temp_trim[15:0];
  assign t2s = $signed({1'b0, trim.temp_trim[31:16]});
  assign t3  = $signed(trim.temp_trim[39:32]);
  assign p1m = $signed({trim.press_trim_a[15], trim.press_trim_a[15:0]}) - 17'sd16384;
  assign p2m = $signed({trim.press_trim_a[31], trim.press_trim_a[31:16]}) - 17'sd16384;
  assign p3  = $signed(trim.press_trim_a[39:32]);
  assign p4  = $signed(trim.press_trim_a[47:40]);
  assign p5s = $signed({1'b0, trim.press_trim_b[15:0]});
  assign p6s = $signed({1'b0, trim.press_trim_b[31:16]});
  assign p7  = $signed(trim.press_trim_b[39:32]);
  assign p8  = $signed(trim.press_trim_b[47:40]);
  assign p9  = $signed(trim.press_trim_c[15:0]);
  assign p10 = $signed(trim.press_trim_c[23:16]);
  assign p11 = $signed(trim.press_trim_c[31:24]);

  logic a_v, b_v, c_v, d_v, e_v, f_v, g_v, h_v, i_v;

  logic signed [25:0] a_d;
  logic [23:0]        a_pr, b_pr, c_pr, d_pr, e_pr, f_pr;
  logic signed [42:0] b_dt2;
  logic signed [51:0] b_dd;
  logic signed [XW-1:0] c_x;

  logic signed [23:0] d_tq, d_tout, e_tq, e_tout, f_tq, f_tout, g_tout, h_tout, i_tout;
  logic               d_sat, e_sat, f_sat, g_sat, h_sat, i_sat;

  logic signed [47:0] e_tt;
  logic signed [49:0] e_pp;
  logic signed [40:0] e_tp2, e_t6, f_t6, g_t6;
  logic signed [41:0] e_p1, f_p1, g_p1;
  logic signed [48:0] e_tpr, f_tpr;

  logic signed [71:0] f_ttt;
  logic signed [74:0] f_ppp;
  logic signed [55:0] f_t7, f_t3, f_tt4, g_t7;
  logic signed [65:0] f_p9, f_t2pr, g_p9, g_t2pr;
  logic signed [57:0] f_p10;

  logic signed [79:0] g_t8;
  logic signed [82:0] g_p11;
  logic signed [80:0] g_t3pr, g_t4lo, g_t4hi;
  logic signed [81:0] g_p10t;

  logic signed [AW-1:0] h_s0, h_s1, h_s2, i_acc;

  // temperature rounding and clipping
  logic signed [XW-1:0] tq_sh, to_sh;
  logic signed [23:0]   tq_clip, to_clip;
  logic                 t_sat;

  always_comb begin
    tq_sh = (c_x + (XW'(1) <<< (btpc_pkg::TQ_SHIFT - 1))) >>> btpc_pkg::TQ_SHIFT;
    to_sh = (c_x + (XW'(1) <<< (btpc_pkg::TOUT_SHIFT - 1))) >>> btpc_pkg::TOUT_SHIFT;
    t_sat = 1'b0;
    if (tq_sh < T_MIN) begin
      tq_clip = T_MIN[23:0];
      t_sat   = 1'b1;
    end else if (tq_sh > T_MAX) begin
      tq_clip = T_MAX[23:0];
      t_sat   = 1'b1;
    end else begin
      tq_clip = tq_sh[23:0];
    end
    if (to_sh < T_MIN) begin
      to_clip = T_MIN[23:0];
      t_sat   = 1'b1;
    end else if (to_sh > T_MAX) begin
      to_clip = T_MAX[23:0];
      t_sat   = 1'b1;
    end else begin
      to_clip = to_sh[23:0];
    end
  end

  // pressure rounding and clipping
  logic [24:0] p_val;
  logic        p_sat;

  always_comb begin
    p_sat = 1'b0;
    if (i_acc[AW-1]) begin
      p_val = '0;
      p_sat = 1'b1;
    end else if (|i_acc[AW-1:btpc_pkg::P_SHIFT+25]) begin
      p_val = '1;
      p_sat = 1'b1;
    end else begin
      p_val = i_acc[btpc_pkg::P_SHIFT+24:btpc_pkg::P_SHIFT];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v   <= 1'b0;
      b_v   <= 1'b0;
      c_v   <= 1'b0;
      d_v   <= 1'b0;
      e_v   <= 1'b0;
      f_v   <= 1'b0;
      g_v   <= 1'b0;
      h_v   <= 1'b0;
      i_v   <= 1'b0;
      out_v <= 1'b0;
    end else begin
      a_v   <= in_v;
      b_v   <= a_v;
      c_v   <= b_v;
      d_v   <= c_v;
      e_v   <= d_v;
      f_v   <= e_v;
      g_v   <= f_v;
      h_v   <= g_v;
      i_v   <= h_v;
      out_v <= i_v;
    end
  end

  always_ff @(posedge clk) begin
    // offset from reference temperature
    a_d  <= $signed({2'b00, in_req.raw_temperature}) - $signed({2'b00, t1, 8'h00});
    a_pr <= in_req.raw_pressure;

    b_dt2 <= a_d * t2s;
    b_dd  <= a_d * a_d;
    b_pr  <= a_pr;

    // linear and quadratic temperature terms with 48 fraction bits
    c_x  <= $signed({b_dt2[42], b_dt2, 18'h00000}) + b_dd * t3;
    c_pr <= b_pr;

    d_tq   <= tq_clip;
    d_tout <= to_clip;
    d_sat  <= t_sat;
    d_pr   <= c_pr;

    e_tt   <= d_tq * d_tq;
    e_pp   <= $signed({1'b0, d_pr}) * $signed({1'b0, d_pr});
    e_tp2  <= d_tq * p2m;
    e_t6   <= d_tq * p6s;
    e_p1   <= $signed({1'b0, d_pr}) * p1m;
    e_tpr  <= d_tq * $signed({1'b0, d_pr});
    e_tq   <= d_tq;
    e_tout <= d_tout;
    e_sat  <= d_sat;
    e_pr   <= d_pr;

    f_ttt  <= e_tt * e_tq;
    f_ppp  <= e_pp * $signed({1'b0, e_pr});
    f_t7   <= e_tt * p7;
    f_t3   <= e_tt * p3;
    f_tt4  <= e_tt * p4;
    f_p9   <= e_pp * p9;
    f_p10  <= e_pp * p10;
    f_t2pr <= e_tp2 * $signed({1'b0, e_pr});
    f_t6   <= e_t6;
    f_p1   <= e_p1;
    f_tpr  <= e_tpr;
    f_tq   <= e_tq;
    f_tout <= e_tout;
    f_sat  <= e_sat;
    f_pr   <= e_pr;

    g_t8   <= f_ttt * p8;
    g_p11  <= f_ppp * p11;
    g_t3pr <= f_t3 * $signed({1'b0, f_pr});
    g_p10t <= f_p10 * f_tq;
    // quartic term split over the two halves of t*pr
    g_t4lo <= f_tt4 * $signed({1'b0, f_tpr[23:0]});
    g_t4hi <= f_tt4 * $signed(f_tpr[48:24]);
    g_t7   <= f_t7;
    g_p9   <= f_p9;
    g_t2pr <= f_t2pr;
    g_t6   <= f_t6;
    g_p1   <= f_p1;
    g_tout <= f_tout;
    g_sat  <= f_sat;

    h_s0 <= (AW'(p5s) <<< 88) + (AW'(g_t6) <<< 63) + (AW'(g_t7) <<< 45)
          + (AW'(g_t8) <<< 22);
    h_s1 <= (AW'(g_p1) <<< 65) + (AW'(g_t2pr) <<< 40) + (AW'(g_t3pr) <<< 21)
          + AW'(g_t4lo) + (AW'(g_t4hi) <<< 24);
    h_s2 <= (AW'(g_p9) <<< 37) + (AW'(g_p10t) <<< 21) + (AW'(g_p11) <<< 20);
    h_tout <= g_tout;
    h_sat  <= g_sat;

    i_acc  <= h_s0 + h_s1 + h_s2 + (AW'(1) <<< (btpc_pkg::P_SHIFT - 1));
    i_tout <= h_tout;
    i_sat  <= h_sat;

    out_res.temperature_q16 <= i_tout;
    out_res.pressure_q8     <= p_val;
    out_res.saturated       <= i_sat | p_sat;
  end

endmodule

// ===== src/btpc_checker.sv =====
// port-level checker for the compensation block, bound to the top level
// depends on btpc_pkg and assert_macros.svh
`include "assert_macros.svh"

module btpc_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  `ASSERT_ALWAYS(a_never_busy, clk, rst, !busy)
  `ASSERT_DELAY(a_req_gives_done, clk, rst, start && !busy, btpc_pkg::LATENCY, done)
  `ASSERT_IMPLY(a_done_has_req, clk, rst, done, $past(start && !busy, btpc_pkg::LATENCY))

endmodule

bind baro_temp_pressure_compensation btpc_checker u_btpc_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);

// ===== verif/baro_temp_pressure_compensation_tb.sv =====
// testbench for baro_temp_pressure_compensation: trims written over APB, raw samples sent,
// each result compared with a local fixed-point prediction of the compensation polynomials
// depends on btpc_pkg and the block's RTL
module baro_temp_pressure_compensation_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [btpc_pkg::ADDR_W-1:0] paddr = '0;
  logic [btpc_pkg::DATA_W-1:0] pwdata = '0;
  logic [btpc_pkg::DATA_W-1:0] prdata;
  logic pready;
  logic start = 1'b0;
  logic busy;
  btpc_pkg::req_t req = '0;
  logic done;
  btpc_pkg::res_t result;

  btpc_pkg::trim_t trims = '0;
  btpc_pkg::res_t comp_due[$];
  int errors = 0;
  int n_req = 0;
  int n_res = 0;
  int n_sat = 0;

  baro_temp_pressure_compensation u_dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .start(start), .busy(busy), .req(req), .done(done), .result(result)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic signed [63:0] clip_q16(logic signed [63:0] v, ref logic sat);
    if (v < -64'sd8388608) begin
      sat = 1'b1;
      return -64'sd8388608;
    end
    if (v > 64'sd8388607) begin
      sat = 1'b1;
      return 64'sd8388607;
    end
    return v;
  endfunction

  function automatic btpc_pkg::res_t compensate(btpc_pkg::req_t r);
    logic sat;
    logic signed [63:0] t1, t2, t3, d, x, tq;
    logic signed [127:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, p10, p11;
    logic signed [127:0] tw1, tw2, tw3, pw1, pw2, pw3, acc;
    btpc_pkg::res_t o;
    sat = 1'b0;
    t1 = $signed({48'd0, trims.temp_trim[15:0]});
    t2 = $signed({48'd0, trims.temp_trim[31:16]});
    t3 = $signed(trims.temp_trim[39:32]);
    p1 = $signed(trims.press_trim_a[15:0]);
    p2 = $signed(trims.press_trim_a[31:16]);
    p3 = $signed(trims.press_trim_a[39:32]);
    p4 = $signed(trims.press_trim_a[47:40]);
    p5 = $signed({112'd0, trims.press_trim_b[15:0]});
    p6 = $signed({112'd0, trims.press_trim_b[31:16]});
    p7 = $signed(trims.press_trim_b[39:32]);
    p8 = $signed(trims.press_trim_b[47:40]);
    p9 = $signed(trims.press_trim_c[15:0]);
    p10 = $signed(trims.press_trim_c[23:16]);
    p11 = $signed(trims.press_trim_c[31:24]);
    d = $signed({40'd0, r.raw_temperature}) - t1 * 64'sd256;
    x = d * t2 * 64'sd262144 + d * d * t3;
    tq = clip_q16((x + (64'sd1 <<< (btpc_pkg::TQ_SHIFT - 1))) >>> btpc_pkg::TQ_SHIFT, sat);
    o.temperature_q16 = tq[23:0];
    tw1 = tq;
    tw2 = tw1 * tw1;
    tw3 = tw2 * tw1;
    pw1 = $signed({104'd0, r.raw_pressure});
    pw2 = pw1 * pw1;
    pw3 = pw2 * pw1;
    acc = p5 <<< 88;
    acc += (tw1 * p6) <<< 63;
    acc += (tw2 * p7) <<< 45;
    acc += (tw3 * p8) <<< 22;
    acc += (pw1 * (p1 - 128'sd16384)) <<< 65;
    acc += (tw1 * (p2 - 128'sd16384) * pw1) <<< 40;
    acc += (tw2 * p3 * pw1) <<< 21;
    acc += tw3 * p4 * pw1;
    acc += (pw2 * p9) <<< 37;
    acc += (pw2 * p10 * tw1) <<< 21;
    acc += (pw3 * p11) <<< 20;
    acc += 128'sd1 <<< (btpc_pkg::P_SHIFT - 1);
    if (acc[127]) begin
      o.pressure_q8 = '0;
      sat = 1'b1;
    end else if ((acc >>> btpc_pkg::P_SHIFT) > 128'sh1FFFFFF) begin
      o.pressure_q8 = '1;
      sat = 1'b1;
    end else begin
      o.pressure_q8 = acc[btpc_pkg::P_SHIFT +: 25];
    end
    o.saturated = sat;
    return o;
  endfunction

  always @(posedge clk) begin
    if (!rst && done) begin
      btpc_pkg::res_t exp_res;
      n_res++;
      if (comp_due.size() == 0) begin
        errors++;
        $display("%0t: result with no request pending, actual %h", $time, result);
      end else begin
        exp_res = comp_due.pop_front();
        if (exp_res.saturated) n_sat++;
        if (result.temperature_q16 !== exp_res.temperature_q16) begin
          errors++;
          $display("%0t: temperature_q16 expected %h actual %h", $time,
                   exp_res.temperature_q16, result.temperature_q16);
        end
        if (result.pressure_q8 !== exp_res.pressure_q8) begin
          errors++;
          $display("%0t: pressure_q8 expected %h actual %h", $time,
                   exp_res.pressure_q8, result.pressure_q8);
        end
        if (result.saturated !== exp_res.saturated) begin
          errors++;
          $display("%0t: saturated expected %b actual %b", $time,
                   exp_res.saturated, result.saturated);
        end
      end
    end
  end

  task automatic write_trim(logic [1:0] idx, logic [63:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      btpc_pkg::REG_TEMP_TRIM:    trims.temp_trim = val[39:0];
      btpc_pkg::REG_PRESS_TRIM_A: trims.press_trim_a = val[47:0];
      btpc_pkg::REG_PRESS_TRIM_B: trims.press_trim_b = val[47:0];
      btpc_pkg::REG_PRESS_TRIM_C: trims.press_trim_c = val[31:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic load_trims(logic [39:0] tt, logic [47:0] pa, logic [47:0] pb,
                            logic [31:0] pc);
    wait (comp_due.size() == 0);
    repeat (btpc_pkg::LATENCY + 2) @(posedge clk);
    write_trim(btpc_pkg::REG_TEMP_TRIM, {24'd0, tt});
    write_trim(btpc_pkg::REG_PRESS_TRIM_A, {16'd0, pa});
    write_trim(btpc_pkg::REG_PRESS_TRIM_B, {16'd0, pb});
    write_trim(btpc_pkg::REG_PRESS_TRIM_C, {32'd0, pc});
  endtask

  task automatic send_sample(logic [23:0] pr, logic [23:0] tr);
    start <= 1'b1;
    req <= '{raw_pressure: pr, raw_temperature: tr};
    do @(posedge clk); while (busy);
    comp_due.push_back(compensate('{raw_pressure: pr, raw_temperature: tr}));
    n_req++;
  endtask

  task automatic maybe_idle(int pct);
    if ($urandom_range(99) < pct) begin
      start <= 1'b0;
      do begin
        req <= {$urandom, 16'($urandom)};
        @(posedge clk);
      end while ($urandom_range(99) < pct);
    end
  endtask

  task automatic rand_trims();
    load_trims({8'($urandom), $urandom}, {16'($urandom), $urandom},
               {16'($urandom), $urandom}, $urandom);
  endtask

  // typical trims: t1 near raw temperature / 256, random pressure terms
  task automatic typical_trims();
    load_trims({8'($urandom_range(0, 255)), 16'($urandom_range(20000, 50000)),
                16'($urandom_range(25000, 32000))},
               {8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom)},
               {8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom)},
               $urandom);
  endtask

  task automatic rand_samples(int n, int pct);
    repeat (n) begin
      if ($urandom_range(3) == 0)
        send_sample(24'($urandom), 24'($urandom));
      else
        send_sample(24'($urandom_range(5000000, 10000000)),
                    24'($urandom_range(6000000, 9000000)));
      maybe_idle(pct);
    end
    start <= 1'b0;
  endtask

  task automatic test_extremes();
    logic [23:0] edges [4] = '{24'h000000, 24'hFFFFFF, 24'h800000, 24'h7FFFFF};
    load_trims('0, '0, '0, '0);
    foreach (edges[i]) send_sample(edges[i], edges[3 - i]);
    start <= 1'b0;
    load_trims('1, '1, '1, '1);
    foreach (edges[i]) send_sample(edges[i], edges[i]);
    start <= 1'b0;
    load_trims({8'h80, 16'hFFFF, 16'h0000}, {8'h80, 8'h80, 16'h8000, 16'h8000},
               {8'h80, 8'h80, 16'hFFFF, 16'hFFFF}, {8'h80, 8'h80, 16'h8000});
    foreach (edges[i]) send_sample(edges[i], edges[i ^ 1]);
    start <= 1'b0;
    load_trims({8'h7F, 16'h5555, 16'hAAAA}, {8'h7F, 8'h7F, 16'h7FFF, 16'h4000},
               {8'h7F, 8'h7F, 16'h5555, 16'hAAAA}, {8'h7F, 8'h7F, 16'h7FFF});
    foreach (edges[i]) send_sample(edges[i], edges[3 - i]);
    start <= 1'b0;
  endtask

  task automatic test_no_gaps();
    typical_trims();
    rand_samples(200, 0);
    rand_trims();
    rand_samples(80, 0);
  endtask

  task automatic test_heavy_gaps();
    typical_trims();
    rand_samples(200, 79);
    rand_trims();
    rand_samples(60, 79);
  endtask

  task automatic test_light_gaps();
    typical_trims();
    rand_samples(200, 21);
    load_trims('1, '0, '1, '0);
    rand_samples(50, 21);
    typical_trims();
    rand_samples(130, 21);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_no_gaps();
    test_heavy_gaps();
    test_light_gaps();
    wait (comp_due.size() == 0);
    repeat (btpc_pkg::LATENCY + 5) @(posedge clk);
    $display("sent %0d samples over several trim sets and gap rates, %0d results, %0d clipped",
             n_req, n_res, n_sat);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("timeout with %0d results pending", comp_due.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== baro_temp_pressure_compensation.f =====
+incdir+src
src/btpc_pkg.sv
src/btpc_pipe.sv
src/baro_temp_pressure_compensation.sv
src/btpc_checker.sv
verif/baro_temp_pressure_compensation_tb.sv
